/* src/tsg_pkg.sv */
// Shared types, register map, command codes and volume table of the sound generator.
package tsg_pkg;

   // Register file geometry.
   localparam int NUM_REGS   = 17;
   localparam int NUM_VOICES = 3;

   // Register map. The floating register collects every selection at or above it.
   localparam logic [4:0] REG_A_COARSE = 5'd1;
   localparam logic [4:0] REG_B_COARSE = 5'd3;
   localparam logic [4:0] REG_C_COARSE = 5'd5;
   localparam logic [4:0] REG_NOISE    = 5'd6;
   localparam logic [4:0] REG_ENABLE   = 5'd7;
   localparam logic [4:0] REG_VOL_A    = 5'd8;
   localparam logic [4:0] REG_ENV_FINE = 5'd11;
   localparam logic [4:0] REG_ENV_CRS  = 5'd12;
   localparam logic [4:0] REG_SHAPE    = 5'd13;
   localparam logic [4:0] REG_FLOAT    = 5'd16;

   // Envelope flag bit positions.
   localparam int ENV_HOLD    = 0;
   localparam int ENV_ALT     = 1;
   localparam int ENV_ATTACK  = 2;
   localparam int ENV_CONT    = 3;
   localparam int ENV_ONESHOT = 4;

   // Noise LFSR feedback pattern, applied after the shift.
   localparam logic [16:0] NOISE_TAPS = 17'h12000;

   // Width of the packed result bus.
   localparam int RSP_DATA_BITS = 72;

   typedef enum logic [2:0] {
      CMD_SELECT = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_TICK   = 3'd3,
      CMD_DECAY  = 3'd4
   } cmd_type;

   // Result of one item. The last member sits in the lowest bits.
   typedef struct packed {
      logic [14:0] level_sum;
      logic [13:0] level_c;
      logic [13:0] level_b;
      logic [13:0] level_a;
      logic [7:0]  read_data;
   } rsp_type;

   // Logarithmic volume table.
   function automatic logic [13:0] vol_level(input logic [3:0] idx);
      logic [13:0] lvl;
      unique case (idx)
         4'd0:  lvl = 14'd0;
         4'd1:  lvl = 14'd112;
         4'd2:  lvl = 14'd167;
         4'd3:  lvl = 14'd238;
         4'd4:  lvl = 14'd346;
         4'd5:  lvl = 14'd506;
         4'd6:  lvl = 14'd693;
         4'd7:  lvl = 14'd1121;
         4'd8:  lvl = 14'd1385;
         4'd9:  lvl = 14'd2168;
         4'd10: lvl = 14'd2889;
         4'd11: lvl = 14'd3685;
         4'd12: lvl = 14'd4672;
         4'd13: lvl = 14'd5630;
         4'd14: lvl = 14'd6948;
         4'd15: lvl = 14'd8192;
         default: lvl = 14'd0;
      endcase
      return lvl;
   endfunction

endpackage

/* src/tsg_core.sv */
// Register file plus tone, noise and envelope generators, stepped once per tick item.
module tsg_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tsg_pkg::cmd_type  cmd,
   input  logic [7:0]        value,
   output tsg_pkg::rsp_type  result
);
   import tsg_pkg::*;

   logic [7:0]  regs_ff [NUM_REGS];
   logic [7:0]  regs_in [NUM_REGS];
   logic [4:0]  sel_ff, sel_in;
   logic [16:0] tone_ff [NUM_VOICES];
   logic [16:0] tone_in [NUM_VOICES];
   logic [4:0]  noise_cnt_ff, noise_cnt_in;
   logic [16:0] noise_shift_ff, noise_shift_in;
   logic [3:0]  wave_ff, wave_in;
   logic [15:0] env_cnt_ff, env_cnt_in;
   logic [3:0]  env_level_ff, env_level_in;
   logic [4:0]  env_flags_ff, env_flags_in;
   logic        env_hold_ff, env_hold_in;
   logic [13:0] level [NUM_VOICES];
   logic        is_tick;

   assign is_tick = cmd_valid && (cmd == CMD_TICK);

   always_comb begin : next_state
      logic [16:0] env_cnt_inc;
      logic [15:0] env_period;
      logic [4:0]  noise_period;
      logic [11:0] tone_period;
      logic [16:0] tone_sum;
      logic [7:0]  data_m;
      logic [3:0]  shape;
      regs_in        = regs_ff;
      sel_in         = sel_ff;
      tone_in        = tone_ff;
      noise_cnt_in   = noise_cnt_ff;
      noise_shift_in = noise_shift_ff;
      wave_in        = wave_ff;
      env_cnt_in     = env_cnt_ff;
      env_level_in   = env_level_ff;
      env_flags_in   = env_flags_ff;
      env_hold_in    = env_hold_ff;
      env_cnt_inc    = {1'b0, env_cnt_ff} + 17'd1;
      env_period     = {regs_ff[REG_ENV_CRS], regs_ff[REG_ENV_FINE]};
      noise_period   = (regs_ff[REG_NOISE][4:0] == 5'd0) ? 5'd1 : regs_ff[REG_NOISE][4:0];
      tone_period    = '0;
      tone_sum       = '0;
      data_m         = value;
      shape          = value[3:0];
      if (cmd_valid) begin
         unique case (cmd)
            CMD_SELECT: begin
               sel_in = (value < 8'(NUM_REGS)) ? value[4:0] : REG_FLOAT;
            end
            CMD_WRITE: begin
               unique case (sel_ff)
                  REG_A_COARSE, REG_B_COARSE, REG_C_COARSE: begin
                     data_m = value & 8'h0f;
                  end
                  REG_NOISE: begin
                     data_m = value & 8'h1f;
                  end
                  REG_SHAPE: begin
                     // A shape write restarts the envelope from its first segment.
                     data_m = value & 8'h0f;
                     if (shape[3:2] == 2'b00) begin
                        shape = 4'd9;
                     end else if (shape[3:2] == 2'b01) begin
                        shape = 4'd15;
                     end
                     env_hold_in  = 1'b0;
                     env_cnt_in   = '0;
                     env_flags_in = {1'b0, shape};
                     env_level_in = shape[ENV_ATTACK] ? 4'd0 : 4'd15;
                  end
                  default: begin
                     data_m = value;
                  end
               endcase
               regs_in[sel_ff] = data_m;
            end
            CMD_TICK: begin
               // Envelope.
               if (!env_hold_ff) begin
                  if (env_cnt_inc < {1'b0, env_period}) begin
                     env_cnt_in = env_cnt_inc[15:0];
                  end else begin
                     env_cnt_in = '0;
                     if (env_flags_ff[ENV_ONESHOT]) begin
                        env_flags_in[ENV_ONESHOT] = 1'b0;
                        if (env_flags_ff[ENV_HOLD]) begin
                           env_hold_in = 1'b1;
                           if (env_flags_ff[ENV_ALT]) begin
                              env_level_in = env_level_ff ^ 4'hf;
                           end
                        end else begin
                           if (env_flags_ff[ENV_ALT]) begin
                              env_flags_in[ENV_ATTACK] = ~env_flags_ff[ENV_ATTACK];
                           end
                           env_level_in = env_flags_in[ENV_ATTACK] ? 4'd0 : 4'd15;
                        end
                     end else if (env_flags_ff[ENV_ATTACK]) begin
                        if (env_level_ff != 4'd15) begin
                           env_level_in = env_level_ff + 4'd1;
                           if (env_level_ff == 4'd14) begin
                              env_flags_in[ENV_ONESHOT] = 1'b1;
                           end
                        end
                     end else begin
                        if (env_level_ff != 4'd0) begin
                           env_level_in = env_level_ff - 4'd1;
                           if (env_level_ff == 4'd1) begin
                              env_flags_in[ENV_ONESHOT] = 1'b1;
                           end
                        end
                     end
                  end
               end
               // Noise, frozen while every noise enable is off.
               if (regs_ff[REG_ENABLE][5:3] != 3'b111) begin
                  noise_cnt_in = noise_cnt_ff + 5'd1;
                  if (noise_cnt_in >= noise_period) begin
                     noise_cnt_in   = '0;
                     wave_in[3]     = noise_shift_ff[0];
                     noise_shift_in = {1'b0, noise_shift_ff[16:1]};
                     if (noise_shift_ff[0]) begin
                        noise_shift_in = noise_shift_in ^ NOISE_TAPS;
                     end
                  end
               end
               // Tone counters.
               for (int v = 0; v < NUM_VOICES; v++) begin
                  tone_period = {regs_ff[2*v+1][3:0], regs_ff[2*v]};
                  if (tone_period == 12'd0) begin
                     tone_period = 12'd1;
                  end
                  tone_sum = tone_ff[v] + 17'd2;
                  if (tone_sum >= {5'd0, tone_period}) begin
                     tone_sum   = tone_sum - {5'd0, tone_period};
                     wave_in[v] = ~wave_ff[v];
                  end
                  tone_in[v] = tone_sum;
               end
            end
            CMD_DECAY: begin
               regs_in[REG_FLOAT] = {1'b0, regs_ff[REG_FLOAT][7:1]};
            end
            default: begin
               regs_in = regs_ff;
            end
         endcase
      end
   end

   always_comb begin : voice_levels
      logic       tone_b;
      logic       noise_b;
      logic [7:0] vol;
      logic [3:0] idx;
      for (int v = 0; v < NUM_VOICES; v++) begin
         tone_b   = wave_in[v] | regs_ff[REG_ENABLE][v];
         noise_b  = wave_in[3] | regs_ff[REG_ENABLE][v+3];
         vol      = regs_ff[int'(REG_VOL_A) + v];
         idx      = vol[4] ? env_level_in : vol[3:0];
         level[v] = (is_tick && tone_b && noise_b) ? vol_level(idx) : 14'd0;
      end
   end

   assign result.read_data = regs_in[sel_in];
   assign result.level_a   = level[0];
   assign result.level_b   = level[1];
   assign result.level_c   = level[2];
   assign result.level_sum = {1'b0, level[0]} + {1'b0, level[1]} + {1'b0, level[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         for (int v = 0; v < NUM_VOICES; v++) begin
            tone_ff[v] <= '0;
         end
         sel_ff         <= '0;
         noise_cnt_ff   <= '0;
         noise_shift_ff <= 17'd1;
         wave_ff        <= '0;
         env_cnt_ff     <= '0;
         env_level_ff   <= 4'd15;
         env_flags_ff   <= 5'h09;
         env_hold_ff    <= 1'b0;
      end else begin
         regs_ff        <= regs_in;
         tone_ff        <= tone_in;
         sel_ff         <= sel_in;
         noise_cnt_ff   <= noise_cnt_in;
         noise_shift_ff <= noise_shift_in;
         wave_ff        <= wave_in;
         env_cnt_ff     <= env_cnt_in;
         env_level_ff   <= env_level_in;
         env_flags_ff   <= env_flags_in;
         env_hold_ff    <= env_hold_in;
      end
   end

endmodule

/* src/three_voice_sound_generator.sv */
// Top level of the three-voice sound generator: stream handshake and result buffering.
//
//   Channel   Direction  Payload
//   req_      in         tuser[2:0] cmd; tdata[7:0] value
//   rsp_      out        tdata: read_data, level_a, level_b, level_c, level_sum
//
// Each accepted item's result is registered into the output register, or into the skid
// register when the output is full and not being taken, so the block takes one item per
// cycle while the skid register is free. All generator state is updated on accept.
// A two-entry output buffer (output register plus skid register) lets the block take
// an item while a finished result is still waiting; req_tready drops only when both
// entries are full. The synchronous reset restores the power-up register file, the
// envelope and the noise seed, and empties the output buffer.
module three_voice_sound_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] value
   input  logic [2:0]                        req_tuser,   // [2:0] cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] read_data, [21:8] level_a, [35:22] level_b, [49:36] level_c,
   // [64:50] level_sum, upper bits zero
   output logic [tsg_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tsg_pkg::*;

   rsp_type core_result;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    accept;
   logic    pop;

   // The skid register must be free before a new item is taken.
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   tsg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (accept),
      .cmd       (cmd_type'(req_tuser)),
      .value     (req_tdata),
      .result    (core_result)
   );

   // Output buffer steering: results leave in order, the skid entry drains first.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = core_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = core_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - $bits(rsp_type)){1'b0}}, out_data_ff};

endmodule

/* dv/sound_readout_checker.sv */
// Checker that predicts every result of the sound generator and compares it with the output stream.
`timescale 1ns / 1ps
module sound_readout_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] value
   input  logic [2:0]                        req_tuser,   // [2:0] cmd
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] read_data, [21:8] level_a, [35:22] level_b, [49:36] level_c,
   // [64:50] level_sum, upper bits zero
   input  logic [tsg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                failures,
   output int                                outstanding,
   output int                                loud_ticks
);
   import tsg_pkg::*;

   localparam int         TONE_FINE_A     = 0;
   localparam logic [3:0] SHAPE_FALL_HOLD = 4'd9;
   localparam logic [3:0] SHAPE_RISE_DROP = 4'd15;
   localparam logic [3:0] LEVEL_TOP       = 4'd15;
   localparam logic [4:0] FLAGS_AT_RESET  = (5'd1 << ENV_HOLD) | (5'd1 << ENV_CONT);

   // Volume curve, entry 0 in the lowest bits.
   localparam logic [15:0][13:0] VOLUME_CURVE = {
      14'd8192, 14'd6948, 14'd5630, 14'd4672, 14'd3685, 14'd2889, 14'd2168, 14'd1385,
      14'd1121, 14'd693,  14'd506,  14'd346,  14'd238,  14'd167,  14'd112,  14'd0
   };

   logic [7:0]  regs [NUM_REGS];
   logic [4:0]  sel;
   logic [16:0] tone_cnt [NUM_VOICES];
   logic [4:0]  noise_cnt;
   logic [16:0] lfsr;
   logic [3:0]  wave;
   logic [15:0] env_cnt;
   logic [3:0]  env_lvl;
   logic [4:0]  env_flags;
   logic        env_frozen;

   rsp_type readout_queue [$];
   int      fail_tally;
   int      loud_tally;

   // Advances one tone counter and returns the level that the voice contributes.
   function automatic logic [13:0] voice_level(input int v);
      logic [11:0] period;
      logic [7:0]  en;
      logic [4:0]  vol;
      period = {regs[REG_A_COARSE + 2 * v][3:0], regs[TONE_FINE_A + 2 * v]};
      if (period == 12'd0)
         period = 12'd1;
      tone_cnt[v] = tone_cnt[v] + 17'd2;
      if (tone_cnt[v] >= {5'd0, period}) begin
         tone_cnt[v] = tone_cnt[v] - {5'd0, period};
         wave[v] = ~wave[v];
      end
      en = regs[REG_ENABLE];
      if (!((wave[v] | en[v]) && (wave[3] | en[v + 3])))
         return 14'd0;
      vol = regs[REG_VOL_A + v][4:0];
      if (vol[4])
         vol = {1'b0, env_lvl};
      return VOLUME_CURVE[vol[3:0]];
   endfunction

   // Applies one command to the shadow state and returns the result it should produce.
   function automatic rsp_type generator_step(input logic [2:0] cmd, input logic [7:0] value);
      rsp_type     r;
      logic [7:0]  data;
      logic [3:0]  shape;
      logic [15:0] env_period;
      logic [4:0]  noise_period;
      r = '0;
      case (cmd)
         CMD_SELECT: sel = (value < NUM_REGS) ? value[4:0] : REG_FLOAT;
         CMD_WRITE: begin
            data = value;
            if (sel == REG_A_COARSE || sel == REG_B_COARSE || sel == REG_C_COARSE) begin
               data[7:4] = 4'd0;
            end else if (sel == REG_NOISE) begin
               data[7:5] = 3'd0;
            end else if (sel == REG_SHAPE) begin
               // A shape write restarts the envelope; the short shapes map onto two
               // full ones while the register itself keeps the written nibble.
               data[7:4] = 4'd0;
               shape = data[3:0];
               if (shape[3:2] == 2'b00)
                  shape = SHAPE_FALL_HOLD;
               else if (shape[3:2] == 2'b01)
                  shape = SHAPE_RISE_DROP;
               env_frozen = 1'b0;
               env_cnt = '0;
               env_flags = {1'b0, shape};
               env_lvl = shape[ENV_ATTACK] ? 4'd0 : LEVEL_TOP;
            end
            regs[sel] = data;
         end
         CMD_TICK: begin
            if (!env_frozen) begin
               env_cnt = env_cnt + 16'd1;
               env_period = {regs[REG_ENV_CRS], regs[REG_ENV_FINE]};
               if (env_cnt >= env_period) begin
                  env_cnt = '0;
                  if (env_flags[ENV_ONESHOT]) begin
                     env_flags[ENV_ONESHOT] = 1'b0;
                     if (env_flags[ENV_HOLD]) begin
                        env_frozen = 1'b1;
                        if (env_flags[ENV_ALT])
                           env_lvl = ~env_lvl;
                     end else begin
                        if (env_flags[ENV_ALT])
                           env_flags[ENV_ATTACK] = ~env_flags[ENV_ATTACK];
                        env_lvl = env_flags[ENV_ATTACK] ? 4'd0 : LEVEL_TOP;
                     end
                  end else if (env_flags[ENV_ATTACK]) begin
                     if (env_lvl != LEVEL_TOP) begin
                        env_lvl = env_lvl + 4'd1;
                        if (env_lvl == LEVEL_TOP)
                           env_flags[ENV_ONESHOT] = 1'b1;
                     end
                  end else if (env_lvl != 4'd0) begin
                     env_lvl = env_lvl - 4'd1;
                     if (env_lvl == 4'd0)
                        env_flags[ENV_ONESHOT] = 1'b1;
                  end
               end
            end
            // The noise source only runs while at least one voice has noise enabled.
            if (regs[REG_ENABLE][5:3] != 3'b111) begin
               noise_cnt = noise_cnt + 5'd1;
               noise_period = regs[REG_NOISE][4:0];
               if (noise_period == 5'd0)
                  noise_period = 5'd1;
               if (noise_cnt >= noise_period) begin
                  noise_cnt = '0;
                  wave[3] = lfsr[0];
                  lfsr = {1'b0, lfsr[16:1]} ^ (lfsr[0] ? NOISE_TAPS : 17'd0);
               end
            end
            r.level_a = voice_level(0);
            r.level_b = voice_level(1);
            r.level_c = voice_level(2);
         end
         CMD_DECAY: regs[REG_FLOAT] = regs[REG_FLOAT] >> 1;
         default: ;
      endcase
      r.read_data = regs[sel];
      r.level_sum = r.level_a + r.level_b + r.level_c;
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            regs[i] = 8'd0;
         for (int i = 0; i < NUM_VOICES; i++)
            tone_cnt[i] = '0;
         sel        = '0;
         noise_cnt  = '0;
         lfsr       = 17'd1;
         wave       = '0;
         env_cnt    = '0;
         env_lvl    = LEVEL_TOP;
         env_flags  = FLAGS_AT_RESET;
         env_frozen = 1'b0;
         readout_queue.delete();
      end else begin
         // A new item is queued before the result check so that the queue order holds
         // even if a result leaves in the cycle its item arrives.
         if (req_tvalid && req_tready)
            readout_queue.push_back(generator_step(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (readout_queue.size() == 0) begin
               $display("%0t ns: result with nothing expected, actual %h", $time, got);
               fail_tally++;
            end else begin
               want = readout_queue.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("level_a", want.level_a, got.level_a);
               check_field("level_b", want.level_b, got.level_b);
               check_field("level_c", want.level_c, got.level_c);
               check_field("level_sum", want.level_sum, got.level_sum);
               check_field("padding", 0, rsp_tdata[RSP_DATA_BITS-1:$bits(rsp_type)]);
               if (want.level_sum != 15'd0)
                  loud_tally++;
            end
         end
      end
      failures    <= fail_tally;
      outstanding <= readout_queue.size();
      loud_ticks  <= loud_tally;
   end

endmodule

/* dv/three_voice_sound_generator_test.sv */
// Testbench top of the sound generator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module three_voice_sound_generator_test;
   import tsg_pkg::*;

   // Spare command codes that the block must treat as no-ops.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   // Fine tone period registers, which the package does not name.
   localparam logic [4:0] REG_A_FINE = 5'd0;
   localparam logic [4:0] REG_B_FINE = 5'd2;
   localparam logic [4:0] REG_C_FINE = 5'd4;

   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 400;
   localparam int RESET_CYCLES  = 9;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = 8'd0;  // [7:0] value
   logic [2:0]               req_tuser  = 3'd0;  // [2:0] cmd
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [7:0] read_data, [21:8] level_a, [35:22] level_b, [49:36] level_c,
   // [64:50] level_sum, upper bits zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int failures;
   int outstanding;
   int loud_ticks;
   int idle_pct  = 0;
   int stall_pct = 0;
   int items_sent;
   int cmd_tally [8];
   int quiet_cycles;

   three_voice_sound_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sound_readout_checker readout_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding),
      .loud_ticks  (loud_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver decides at every falling edge whether it takes a result in the next
   // cycle. Its stall rate follows the current phase.
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // The watchdog ends the run when neither channel has moved for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired at %0t ns with %0d results still due.",
                     $time, outstanding);
            $display("three_voice_sound_generator_test failed");
            $finish;
         end
      end
   end

   // Presents one item, starting at a falling edge, and returns at the falling edge after
   // the item has been taken. Before the item the sender may sit idle, while tvalid stays
   // high between back-to-back items.
   task automatic send_item(input logic [2:0] cmd, input logic [7:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      cmd_tally[cmd]++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int          pick;
      int          phase_start;
      logic [4:0]  target;
      logic [7:0]  data;
      int          phase_idle  [PHASES];
      int          phase_stall [PHASES];

      // No idling, a slow sender, a slow receiver, then both slow.
      phase_idle  = '{0, 71, 0, 23};
      phase_stall = '{0, 0, 71, 23};
      items_sent  = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The first tick runs from the reset state, where every tone and
      // noise gate is open but all volumes are zero and the envelope period is zero.
      send_item(CMD_TICK, 8'h00);
      // Any register number past the end lands on the floating register, which the
      // decay command then shifts down.
      send_item(CMD_SELECT, 8'hFF);
      send_item(CMD_WRITE, 8'hFF);
      send_item(CMD_DECAY, 8'h00);
      send_item(CMD_READ, 8'hFF);
      send_item(CMD_SELECT, 8'h10);
      // Write masks on a coarse tone register and on the noise period.
      send_item(CMD_SELECT, {3'd0, REG_A_COARSE});
      send_item(CMD_WRITE, 8'hFF);
      send_item(CMD_SELECT, {3'd0, REG_NOISE});
      send_item(CMD_WRITE, 8'hFF);
      // Shape writes: a short falling shape, a short rising shape and a masked full byte.
      send_item(CMD_SELECT, {3'd0, REG_SHAPE});
      send_item(CMD_WRITE, 8'h00);
      send_item(CMD_WRITE, 8'h04);
      send_item(CMD_WRITE, 8'hFF);
      // Voice A follows the envelope.
      send_item(CMD_SELECT, {3'd0, REG_VOL_A});
      send_item(CMD_WRITE, 8'h1F);
      // All noise gates closed, so the noise source must stand still.
      send_item(CMD_SELECT, {3'd0, REG_ENABLE});
      send_item(CMD_WRITE, 8'h38);
      send_item(CMD_TICK, 8'hFF);
      // Fine period zero, but voice A keeps its coarse 0xF, so its tone period is nonzero.
      send_item(CMD_SELECT, {3'd0, REG_A_FINE});
      send_item(CMD_WRITE, 8'h00);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'h55);
      // Spare command codes change nothing.
      send_item(CMD_SPARE_HI, 8'h00);
      send_item(CMD_SPARE_LO, 8'hAA);

      for (int phase = 0; phase < PHASES; phase++) begin
         idle_pct    = phase_idle[phase];
         stall_pct   = phase_stall[phase];
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               // Program one register. Periods are kept short most of the time so that
               // tones, noise and envelopes actually turn over within the run.
               target = 5'($urandom_range(0, REG_FLOAT - 1));
               data   = 8'($urandom_range(0, 255));
               if (target == REG_A_COARSE || target == REG_B_COARSE ||
                   target == REG_C_COARSE || target == REG_ENV_CRS) begin
                  if ($urandom_range(0, 3) != 0)
                     data = 8'd0;
               end else if (target == REG_A_FINE || target == REG_B_FINE ||
                            target == REG_C_FINE || target == REG_ENV_FINE) begin
                  if ($urandom_range(0, 4) < 3)
                     data = 8'($urandom_range(0, 12));
               end
               send_item(CMD_SELECT, {3'd0, target});
               send_item(CMD_WRITE, data);
               if ($urandom_range(0, 4) == 0)
                  send_item(CMD_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
               repeat ($urandom_range(1, 24))
                  send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
               send_item($urandom_range(0, 1) ? CMD_READ : CMD_DECAY,
                         8'($urandom_range(0, 255)));
            end else begin
               // Loose items: any register number, a write to whatever is selected,
               // or a spare code.
               case ($urandom_range(0, 2))
                  0:       send_item(CMD_SELECT, 8'($urandom_range(0, 255)));
                  1:       send_item(CMD_WRITE, 8'($urandom_range(0, 255)));
                  default: send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                                     8'($urandom_range(0, 255)));
               endcase
            end
         end
      end

      req_tvalid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items over four handshake phases: %0d selects, %0d writes, %0d reads,",
               items_sent, cmd_tally[CMD_SELECT], cmd_tally[CMD_WRITE], cmd_tally[CMD_READ]);
      $display("%0d decays, %0d ticks (%0d audible), %0d spare codes; %0d mismatches.",
               cmd_tally[CMD_DECAY], cmd_tally[CMD_TICK], loud_ticks,
               cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_LO + 3'd1] +
               cmd_tally[CMD_SPARE_HI], failures);
      if (failures == 0 && outstanding == 0) begin
         $display("three_voice_sound_generator_test passed");
      end else begin
         $display("three_voice_sound_generator_test failed");
      end
      $finish;
   end

endmodule
